### hw/rtl/mmb_pkg.sv
package mmb_pkg;

    // Item kinds
    localparam logic [1:0] KIND_STORE = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam int MSG_LEN_DEF = 32;

    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [4:0] DARK_SLOTS = 5'd4;

    // Memory port controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    // Visible player status
    typedef struct packed {
        logic led;
        logic active;
    } t_status;

    // Timing pattern of a letter, bit 0 plays first
    function automatic logic [15:0] letter_pattern(input logic [4:0] idx);
        logic [15:0] pat;
        begin
            case (idx)
                5'd0:    pat = 16'h001D;
                5'd1:    pat = 16'h0157;
                5'd2:    pat = 16'h05D7;
                5'd3:    pat = 16'h0057;
                5'd4:    pat = 16'h0001;
                5'd5:    pat = 16'h0175;
                5'd6:    pat = 16'h0177;
                5'd7:    pat = 16'h0055;
                5'd8:    pat = 16'h0005;
                5'd9:    pat = 16'h1DDD;
                5'd10:   pat = 16'h01D7;
                5'd11:   pat = 16'h015D;
                5'd12:   pat = 16'h0077;
                5'd13:   pat = 16'h0017;
                5'd14:   pat = 16'h0777;
                5'd15:   pat = 16'h05DD;
                5'd16:   pat = 16'h1D77;
                5'd17:   pat = 16'h005D;
                5'd18:   pat = 16'h0015;
                5'd19:   pat = 16'h0007;
                5'd20:   pat = 16'h0075;
                5'd21:   pat = 16'h01D5;
                5'd22:   pat = 16'h01DD;
                5'd23:   pat = 16'h0757;
                5'd24:   pat = 16'h1DD7;
                5'd25:   pat = 16'h0577;
                default: pat = 16'h0000;
            endcase
            return pat;
        end
    endfunction

    // Number of slots in a letter's pattern
    function automatic logic [4:0] letter_length(input logic [4:0] idx);
        logic [4:0] len;
        begin
            case (idx)
                5'd0:    len = 5'd8;
                5'd1:    len = 5'd12;
                5'd2:    len = 5'd14;
                5'd3:    len = 5'd10;
                5'd4:    len = 5'd4;
                5'd5:    len = 5'd12;
                5'd6:    len = 5'd12;
                5'd7:    len = 5'd10;
                5'd8:    len = 5'd6;
                5'd9:    len = 5'd16;
                5'd10:   len = 5'd12;
                5'd11:   len = 5'd12;
                5'd12:   len = 5'd10;
                5'd13:   len = 5'd8;
                5'd14:   len = 5'd14;
                5'd15:   len = 5'd14;
                5'd16:   len = 5'd16;
                5'd17:   len = 5'd10;
                5'd18:   len = 5'd8;
                5'd19:   len = 5'd6;
                5'd20:   len = 5'd10;
                5'd21:   len = 5'd12;
                5'd22:   len = 5'd12;
                5'd23:   len = 5'd14;
                5'd24:   len = 5'd16;
                5'd25:   len = 5'd14;
                default: len = 5'd0;
            endcase
            return len;
        end
    endfunction

endpackage

### hw/rtl/mmb_msg_mem.sv
module mmb_msg_mem #(
    parameter int MSG_LEN = mmb_pkg::MSG_LEN_DEF,
    parameter int AW      = $clog2(MSG_LEN)
) (
    input  logic              i_clk,
    input  mmb_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [MSG_LEN];
    logic [7:0] r_rd_data;

    // Write one character
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/mmb_player.sv
module mmb_player #(
    parameter int MSG_LEN = mmb_pkg::MSG_LEN_DEF,
    parameter int AW      = $clog2(MSG_LEN),
    parameter int PW      = $clog2(MSG_LEN + 2)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_kind,
    input  logic [4:0]        i_slot,
    input  logic [7:0]        i_letter,
    input  logic              i_repeat_flag,
    input  logic [7:0]        i_rd_data,
    output mmb_pkg::t_mem_ctl o_mem_ctl,
    output logic [AW-1:0]     o_wr_addr,
    output logic [AW-1:0]     o_rd_addr,
    output mmb_pkg::t_status  o_next
);

    localparam logic [PW-1:0] POS_END = PW'(MSG_LEN);

    // Playback state
    logic [PW-1:0] r_pos, n_pos;
    logic          r_active, n_active;
    logic          r_looping, n_looping;
    logic [15:0]   r_shift, n_shift;
    logic [4:0]    r_slots, n_slots;
    logic          r_led, n_led;
    // Character cache: entry 0 and the entry at r_pos
    logic [7:0]    r_first, n_first;
    logic [7:0]    r_next, n_next;
    logic          r_pend, n_pend;

    logic [AW+4:0] slot_wide;
    logic [AW-1:0] slot_addr;
    logic          slot_ok;
    logic [7:0]    cur_chr;
    logic [7:0]    chr;
    logic [7:0]    chr_off;
    logic [PW-1:0] new_pos;
    logic          stop;
    logic [15:0]   pat;
    logic [4:0]    pat_len;

    assign slot_wide = (AW + 5)'(i_slot);
    assign slot_addr = slot_wide[AW-1:0];
    assign slot_ok   = (32'(i_slot) < 32'(MSG_LEN));

    // Character at the current read position
    always_comb begin
        if (r_pos == '0) begin
            cur_chr = r_first;
        end else if (r_pos >= POS_END) begin
            cur_chr = 8'd0;
        end else if (r_pend) begin
            cur_chr = i_rd_data;
        end else begin
            cur_chr = r_next;
        end
    end

    // Next state for the accepted word
    always_comb begin
        n_pos     = r_pos;
        n_active  = r_active;
        n_looping = r_looping;
        n_shift   = r_shift;
        n_slots   = r_slots;
        n_led     = r_led;
        n_first   = r_first;
        n_next    = r_pend ? i_rd_data : r_next;
        n_pend    = 1'b0;
        o_mem_ctl = '0;
        o_wr_addr = slot_addr;
        o_rd_addr = '0;
        chr       = cur_chr;
        chr_off   = cur_chr - mmb_pkg::CHAR_A;
        new_pos   = r_pos;
        stop      = 1'b0;
        pat       = '0;
        pat_len   = '0;

        if (i_accept) begin
            unique case (i_kind)
                mmb_pkg::KIND_STORE: begin
                    if (slot_ok) begin
                        o_mem_ctl.wr_en = 1'b1;
                        if (slot_addr == '0) begin
                            n_first = i_letter;
                        end
                        if (r_pos == PW'(slot_wide)) begin
                            n_next = i_letter;
                        end
                    end
                end
                mmb_pkg::KIND_START: begin
                    n_pos     = '0;
                    n_active  = 1'b1;
                    n_looping = i_repeat_flag;
                    n_led     = 1'b0;
                end
                mmb_pkg::KIND_TICK: begin
                    if (r_active) begin
                        if (r_slots == '0) begin
                            // Fetch the next character
                            new_pos = (r_pos <= POS_END) ? r_pos + 1'b1 : r_pos;
                            if (cur_chr == 8'd0) begin
                                if (r_looping) begin
                                    chr     = r_first;
                                    new_pos = PW'(1);
                                end else begin
                                    stop = 1'b1;
                                end
                            end
                            chr_off = chr - mmb_pkg::CHAR_A;
                            n_pos   = new_pos;
                            // Prefetch the character after this one
                            if (new_pos < POS_END) begin
                                o_mem_ctl.rd_en = 1'b1;
                                o_rd_addr       = new_pos[AW-1:0];
                                n_pend          = 1'b1;
                            end
                            if (stop) begin
                                n_active = 1'b0;
                            end else begin
                                if (chr >= mmb_pkg::CHAR_A && chr <= mmb_pkg::CHAR_Z) begin
                                    pat     = mmb_pkg::letter_pattern(chr_off[4:0]);
                                    pat_len = mmb_pkg::letter_length(chr_off[4:0]);
                                    n_led   = pat[0];
                                    n_shift = pat >> 1;
                                    n_slots = pat_len - 1'b1;
                                end else begin
                                    n_led   = 1'b0;
                                    n_shift = '0;
                                    n_slots = mmb_pkg::DARK_SLOTS - 1'b1;
                                end
                            end
                        end else begin
                            // Shift out one slot
                            n_led   = r_shift[0];
                            n_shift = r_shift >> 1;
                            n_slots = r_slots - 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_active  <= 1'b0;
            r_looping <= 1'b0;
            r_shift   <= '0;
            r_slots   <= '0;
            r_led     <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_active  <= n_active;
            r_looping <= n_looping;
            r_shift   <= n_shift;
            r_slots   <= n_slots;
            r_led     <= n_led;
            r_pend    <= n_pend;
        end
    end

    // Cached characters
    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_next  <= n_next;
    end

    assign o_next.led    = n_led;
    assign o_next.active = n_active;

endmodule

### hw/rtl/morse_message_blinker_top.sv
// Morse message blinker: plays a stored message on one LED, one slot per tick.
// Input channel (i_in_valid / o_in_ready) carries one word per item:
//   i_kind 0 stores i_letter at message position i_slot, 1 starts playback
//   from position 0 with loop mode i_repeat_flag, 2 advances one time slot.
// Output channel (o_out_valid / i_out_ready) returns one word per input word:
//   o_led_level is the LED drive and o_playing the run flag after that word.
// The result word is registered at the edge that accepts the input word.
// Throughput is one word per cycle while the receiver takes results; the
// message memory is read ahead of use, so the lookup never stalls input.
// When the receiver stalls, the result stays in the output register and the
// input is held off until it is taken; input is accepted in the same cycle
// the held result leaves.
// Reset clears playback (LED off, not playing) and the output valid flag.
// Message memory content is not cleared; read only positions that were
// written before playback reaches them.
module morse_message_blinker_top #(
    parameter int MSG_LEN = mmb_pkg::MSG_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [4:0] i_slot,
    input  logic [7:0] i_letter,
    input  logic       i_repeat_flag,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_led_level,
    output logic       o_playing
);

    localparam int AW = $clog2(MSG_LEN);

    mmb_pkg::t_mem_ctl mem_ctl;
    mmb_pkg::t_status  next_status;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        rd_data;
    logic              in_acc;

    logic r_out_valid, n_out_valid;
    logic r_out_led, n_out_led;
    logic r_out_play, n_out_play;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    mmb_player #(
        .MSG_LEN (MSG_LEN)
    ) u_player (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_acc),
        .i_kind        (i_kind),
        .i_slot        (i_slot),
        .i_letter      (i_letter),
        .i_repeat_flag (i_repeat_flag),
        .i_rd_data     (rd_data),
        .o_mem_ctl     (mem_ctl),
        .o_wr_addr     (wr_addr),
        .o_rd_addr     (rd_addr),
        .o_next        (next_status)
    );

    mmb_msg_mem #(
        .MSG_LEN (MSG_LEN)
    ) u_msg_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_letter),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Load a result word on accept, drop it when taken
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_led   = r_out_led;
        n_out_play  = r_out_play;
        if (in_acc) begin
            n_out_valid = 1'b1;
            n_out_led   = next_status.led;
            n_out_play  = next_status.active;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_led  <= n_out_led;
        r_out_play <= n_out_play;
    end

    assign o_out_valid = r_out_valid;
    assign o_led_level = r_out_led;
    assign o_playing   = r_out_play;

`ifndef ASSERT_OFF
    // A start word reports playing with the LED off
    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind == mmb_pkg::KIND_START) |=> (o_out_valid && o_playing && !o_led_level))
        else $error("start word did not report playing with LED off");

    // An empty output register never blocks input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input held off with empty output register");

    // A store word leaves the playback status unchanged
    a_store_keeps_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind == mmb_pkg::KIND_STORE && $past(in_acc))
        |=> (o_led_level == $past(o_led_level) && o_playing == $past(o_playing)))
        else $error("store word changed playback status");

    // Nothing starts playback but a start word
    a_no_spurious_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind != mmb_pkg::KIND_START && !next_status.active) |=> !o_playing)
        else $error("playback began without a start word");
`endif

endmodule

### sim/morse_blink_checker.sv
`timescale 1ns / 1ps

module morse_blink_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_kind,
    input  logic [4:0] i_slot,
    input  logic [7:0] i_letter,
    input  logic       i_repeat_flag,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_led_level,
    input  logic       i_playing,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    localparam int STORE_DEPTH = mmb_pkg::MSG_LEN_DEF;

    // Dot/dash timing of A..Z, 16 bits per letter, A in the low bits, bit 0 plays first
    localparam logic [26*16-1:0] MORSE_CODES = {
        16'h0577, 16'h1DD7, 16'h0757, 16'h01DD, 16'h01D5, 16'h0075, 16'h0007,
        16'h0015, 16'h005D, 16'h1D77, 16'h05DD, 16'h0777, 16'h0017, 16'h0077,
        16'h015D, 16'h01D7, 16'h1DDD, 16'h0005, 16'h0055, 16'h0177, 16'h0175,
        16'h0001, 16'h0057, 16'h05D7, 16'h0157, 16'h001D
    };

    // Predicted player state
    logic [7:0]  msg_copy [STORE_DEPTH];
    logic [5:0]  fetch_pos;
    logic        run_q;
    logic        loop_q;
    logic        led_q;
    logic [15:0] shift_q;
    logic [4:0]  slots_q;

    mmb_pkg::t_status status_due [$];
    int fails;
    int seen;

    // Slots of a letter: its lit pattern plus the three dark slots of the letter gap
    function automatic logic [4:0] code_slots(input logic [15:0] code);
        logic [4:0] top;
        begin
            top = 5'd0;
            for (int b = 0; b < 16; b++) begin
                if (code[b]) top = 5'(b);
            end
            return top + 5'd4;
        end
    endfunction

    // Read the next message character; past the store it reads as the end mark
    function automatic logic [7:0] fetch_next();
        logic [7:0] c;
        begin
            c = 8'h00;
            if (fetch_pos < STORE_DEPTH) c = msg_copy[fetch_pos[$clog2(STORE_DEPTH)-1:0]];
            if (fetch_pos <= STORE_DEPTH) fetch_pos = fetch_pos + 6'd1;
            return c;
        end
    endfunction

    // Load a letter's pattern, or four dark slots for anything outside A..Z
    function automatic void load_letter(input logic [7:0] c);
        logic [7:0] idx;
        begin
            if (c >= mmb_pkg::CHAR_A && c <= mmb_pkg::CHAR_Z) begin
                idx = c - mmb_pkg::CHAR_A;
                shift_q = MORSE_CODES[idx*16 +: 16];
                slots_q = code_slots(shift_q);
            end else begin
                shift_q = 16'h0000;
                slots_q = mmb_pkg::DARK_SLOTS;
            end
        end
    endfunction

    // Advance playback by one time slot
    function automatic void advance_slot();
        logic [7:0] c;
        logic       go;
        begin
            go = run_q;
            if (run_q && slots_q == 5'd0) begin
                c = fetch_next();
                if (c == 8'h00) begin
                    if (loop_q) begin
                        fetch_pos = 6'd0;
                        c = fetch_next();
                    end else begin
                        run_q = 1'b0;
                        go = 1'b0;
                    end
                end
                if (go) load_letter(c);
            end
            if (go) begin
                led_q = shift_q[0];
                shift_q = shift_q >> 1;
                slots_q = slots_q - 5'd1;
            end
        end
    endfunction

    // Apply one input word and return the LED/run status it leaves
    function automatic mmb_pkg::t_status play_word(input logic [1:0] kind,
                                                   input logic [4:0] slot,
                                                   input logic [7:0] letter,
                                                   input logic rep);
        mmb_pkg::t_status st;
        begin
            case (kind)
                mmb_pkg::KIND_STORE: begin
                    msg_copy[slot] = letter;
                end
                mmb_pkg::KIND_START: begin
                    fetch_pos = 6'd0;
                    run_q = 1'b1;
                    loop_q = rep;
                    led_q = 1'b0;
                end
                mmb_pkg::KIND_TICK: begin
                    advance_slot();
                end
                default: begin
                end
            endcase
            st.led = led_q;
            st.active = run_q;
            return st;
        end
    endfunction

    // Predict on accepted input words, compare accepted result words in order
    always @(posedge i_clk) begin : watch
        mmb_pkg::t_status want;
        if (!i_rst_n) begin
            fetch_pos = 6'd0;
            run_q = 1'b0;
            loop_q = 1'b0;
            led_q = 1'b0;
            shift_q = 16'h0000;
            slots_q = 5'd0;
            status_due.delete();
            fails = 0;
            seen = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                status_due.push_back(play_word(i_kind, i_slot, i_letter, i_repeat_flag));
            end
            if (i_out_valid && i_out_ready) begin
                seen++;
                if (status_due.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("%0t: result word %0d with nothing pending (led %0b playing %0b)",
                                 $time, seen, i_led_level, i_playing);
                    end
                end else begin
                    want = status_due.pop_front();
                    if (want.led !== i_led_level || want.active !== i_playing) begin
                        fails++;
                        if (fails <= 10) begin
                            $display({"%0t: result word %0d: led exp %0b got %0b, ",
                                      "playing exp %0b got %0b"},
                                     $time, seen, want.led, i_led_level,
                                     want.active, i_playing);
                        end
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= status_due.size();
        o_checked <= seen;
    end

endmodule

### sim/morse_message_blinker_top_test.sv
`timescale 1ns / 1ps

module morse_message_blinker_top_test;

    localparam int         STORE_DEPTH = mmb_pkg::MSG_LEN_DEF;
    localparam int         WORD_TARGET = 1375;
    localparam logic [1:0] KIND_SPARE  = 2'd3;
    // Short letters keep a full-store message brief
    localparam logic [7*8-1:0] QUICK_LETTERS = "ETIANMS";

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_kind = mmb_pkg::KIND_TICK;
    logic [4:0] i_slot = 5'd0;
    logic [7:0] i_letter = 8'h00;
    logic       i_repeat_flag = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_led_level;
    logic       o_playing;

    int fail_count;
    int status_pending;
    int results_checked;

    int tx_idle_pct = 37;
    int rx_stall_pct = 59;
    int words_sent = 0;
    int stores_sent = 0;
    int starts_sent = 0;
    int ticks_sent = 0;
    int spares_sent = 0;
    int messages_played = 0;
    int full_store_runs = 0;

    // Shadow of the message store, used to keep every message terminated
    logic [7:0] msg_shadow [STORE_DEPTH];
    logic       msg_written [STORE_DEPTH];

    morse_message_blinker_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_slot        (i_slot),
        .i_letter      (i_letter),
        .i_repeat_flag (i_repeat_flag),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_led_level   (o_led_level),
        .o_playing     (o_playing)
    );

    morse_blink_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_slot        (i_slot),
        .i_letter      (i_letter),
        .i_repeat_flag (i_repeat_flag),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_led_level   (o_led_level),
        .i_playing     (o_playing),
        .o_fail_count  (fail_count),
        .o_pending     (status_pending),
        .o_checked     (results_checked)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Stall the result channel at random
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Send one word: idle at random, then hold it until the block takes it
    task automatic send_word(input logic [1:0] kind, input logic [4:0] slot,
                             input logic [7:0] letter, input logic rep);
        begin
            if (words_sent < WORD_TARGET / 3) begin
                tx_idle_pct = 37;
                rx_stall_pct = 59;
            end else if (words_sent < 2 * WORD_TARGET / 3) begin
                tx_idle_pct = 59;
                rx_stall_pct = 37;
            end else begin
                tx_idle_pct = 0;
                rx_stall_pct = 0;
            end
            while ($urandom_range(0, 99) < tx_idle_pct) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_kind <= kind;
            i_slot <= slot;
            i_letter <= letter;
            i_repeat_flag <= rep;
            @(negedge i_clk);
            while (!o_in_ready) @(negedge i_clk);
            @(posedge i_clk);
            words_sent++;
            case (kind)
                mmb_pkg::KIND_STORE: stores_sent++;
                mmb_pkg::KIND_START: starts_sent++;
                mmb_pkg::KIND_TICK:  ticks_sent++;
                default:             spares_sent++;
            endcase
        end
    endtask

    task automatic send_tick();
        send_word(mmb_pkg::KIND_TICK, 5'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic send_start(input logic rep);
        send_word(mmb_pkg::KIND_START, 5'($urandom), 8'($urandom), rep);
    endtask

    // True when, after the write, every message from position 0 ends on a
    // written zero or runs to the end of the store through written entries
    function automatic logic stays_terminated(input logic [4:0] slot, input logic [7:0] letter);
        logic [7:0] c;
        begin
            for (int p = 0; p < STORE_DEPTH; p++) begin
                if (p == slot) begin
                    c = letter;
                end else if (!msg_written[p]) begin
                    return 1'b0;
                end else begin
                    c = msg_shadow[p];
                end
                if (c == 8'h00) return 1'b1;
            end
            return 1'b1;
        end
    endfunction

    // Store a character; turn it into the end mark if playback could run
    // into an unwritten entry otherwise
    task automatic store_char(input logic [4:0] slot, input logic [7:0] letter);
        logic [7:0] c;
        begin
            c = stays_terminated(slot, letter) ? letter : 8'h00;
            msg_shadow[slot] = c;
            msg_written[slot] = 1'b1;
            send_word(mmb_pkg::KIND_STORE, slot, c, 1'($urandom));
        end
    endtask

    // Mostly letters, now and then any other nonzero code
    function automatic logic [7:0] pick_letter();
        begin
            if ($urandom_range(0, 99) < 85) return mmb_pkg::CHAR_A + 8'($urandom_range(0, 25));
            if ($urandom_range(0, 1)) return 8'($urandom_range(1, 8'h40));
            return 8'($urandom_range(8'h5B, 8'hFF));
        end
    endfunction

    // Write a message of len characters back to front, start it, then tick;
    // unless quick, a few restarts and rewrites land while it plays
    task automatic play_message(input int len, input logic rep, input int ticks,
                                input logic quick);
        logic [7:0] c;
        int r;
        begin
            if (len < STORE_DEPTH) store_char(5'(len), 8'h00);
            for (int k = len - 1; k >= 0; k--) begin
                c = quick ? QUICK_LETTERS[$urandom_range(0, 6)*8 +: 8] : pick_letter();
                store_char(5'(k), c);
            end
            send_start(rep);
            messages_played++;
            if (len == STORE_DEPTH) full_store_runs++;
            for (int n = 0; n < ticks; n++) begin
                r = $urandom_range(0, 99);
                if (quick || r >= 5) begin
                    send_tick();
                end else if (r < 2) begin
                    send_start(1'($urandom));
                end else begin
                    store_char(5'($urandom_range(0, STORE_DEPTH - 1)), pick_letter());
                end
            end
        end
    endtask

    // Stray words between messages
    task automatic stray_words();
        int r;
        begin
            repeat ($urandom_range(1, 6)) begin
                r = $urandom_range(0, 3);
                case (r)
                    0: store_char(5'($urandom), 8'($urandom));
                    1: send_word(KIND_SPARE, 5'($urandom), 8'($urandom), 1'($urandom));
                    2: send_start(1'($urandom));
                    default: send_tick();
                endcase
            end
        end
    endtask

    initial begin
        int episode;
        int len;
        int r;
        for (int p = 0; p < STORE_DEPTH; p++) begin
            msg_written[p] = 1'b0;
            msg_shadow[p] = 8'h00;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Tick while idle, then the unused kind with all payload bits set
        send_tick();
        send_word(KIND_SPARE, 5'd31, 8'hFF, 1'b1);
        // Empty looping message: position 0 holds the end mark
        store_char(5'd0, 8'h00);
        send_start(1'b1);
        repeat (5) send_tick();
        // Play once on an empty message: stops at the first fetch
        send_start(1'b0);
        send_tick();
        // Message A, Z, a code outside A..Z, end; last slot written too
        store_char(5'd3, 8'h00);
        store_char(5'd2, 8'hFF);
        store_char(5'd1, mmb_pkg::CHAR_Z);
        store_char(5'd0, mmb_pkg::CHAR_A);
        store_char(5'd31, 8'h45);
        send_start(1'b0);
        repeat (3) send_tick();
        // Restart while a letter is still playing
        send_start(1'b1);
        repeat (2) send_tick();

        episode = 0;
        while (words_sent < WORD_TARGET) begin
            if (episode == 2) begin
                // Fill the whole store so playback runs off its end
                play_message(STORE_DEPTH, 1'b0, 340, 1'b1);
            end else if ($urandom_range(0, 99) < 75) begin
                r = $urandom_range(0, 29);
                if (r == 0) len = STORE_DEPTH;
                else if (r < 4) len = 0;
                else len = $urandom_range(1, 6);
                play_message(len, 1'($urandom), (len == 0) ? $urandom_range(2, 12)
                             : $urandom_range(len * 6, len * 16 + 10), 1'b0);
            end else begin
                stray_words();
            end
            episode++;
        end
        i_in_valid <= 1'b0;

        // Drain the result channel, then let the clock run on before the summary
        @(negedge i_clk);
        while (status_pending != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d words: %0d stores, %0d starts, %0d ticks, %0d of the unused kind.",
                 words_sent, stores_sent, starts_sent, ticks_sent, spares_sent);
        $display("Played %0d messages (%0d filling the store), checked %0d result words.",
                 messages_played, full_store_runs, results_checked);
        if (fail_count == 0 && status_pending == 0) begin
            $display("morse_message_blinker_top: match");
        end else begin
            $display("morse_message_blinker_top: mismatch");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #20_000_000;
        $display("morse_message_blinker_top: mismatch");
        $finish;
    end

endmodule

### sim.f
hw/rtl/mmb_pkg.sv
hw/rtl/mmb_msg_mem.sv
hw/rtl/mmb_player.sv
hw/rtl/morse_message_blinker_top.sv
sim/morse_blink_checker.sv
sim/morse_message_blinker_top_test.sv
